@@ src/fat16_pkg.sv @@
`timescale 1ns / 1ps

package fat16_pkg;

  // Table geometry.
  localparam int FAT_ENTRIES = 4096;
  localparam int ADDR_W      = $clog2(FAT_ENTRIES);
  localparam logic [16:0] FAT_LIMIT = 17'(FAT_ENTRIES);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(FAT_ENTRIES - 1);
  localparam logic [ADDR_W-1:0] ADDR_FIRST_DATA = ADDR_W'(2);

  // Width of the chain length and free counters.
  localparam int CNT_W = 13;

  // Entry values.
  localparam logic [7:0]  MEDIA_BYTE    = 8'hF8;
  localparam logic [15:0] ENTRY_FREE    = 16'h0000;
  localparam logic [15:0] ENTRY_END     = 16'hFFFF;
  localparam logic [15:0] ENTRY_END_MIN = 16'hFFF8;
  localparam logic [15:0] ENTRY_RSV0    = {8'hFF, MEDIA_BYTE};

  // Request modes.
  localparam logic [2:0] MODE_GET   = 3'd0;
  localparam logic [2:0] MODE_SET   = 3'd1;
  localparam logic [2:0] MODE_FIND  = 3'd2;
  localparam logic [2:0] MODE_ALLOC = 3'd3;
  localparam logic [2:0] MODE_FREE  = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

endpackage

@@ src/fat16_cluster_table_engine.sv @@
`timescale 1ns / 1ps

// Channel   Ports                                          Direction
// -------   --------------------------------------------   ---------
// request   in_valid in_ready in_mode in_cluster           in
//           in_value in_cluster_count
// result    out_valid out_ready out_found_cluster          out
//           out_entry_value out_status
//
// The table sits in one single-port memory, and every request is served by a
// sequencer that makes one memory access per cycle, so one request is taken at
// a time. Get reads an entry and set writes one. Find reads and checks the
// entries one at a time. Allocate first counts free entries, then scans them
// again, marking and linking each one it takes. Free walks the chain link by link.
// After reset a clearing pass writes all 4096 entries, one per cycle, before
// the first request is accepted. A stalled result is held in the output
// register while the next request is already accepted and worked on.
module fat16_cluster_table_engine
  import fat16_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [15:0] in_cluster,
  input  logic [15:0] in_value,
  input  logic [12:0] in_cluster_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_found_cluster,
  output logic [15:0] out_entry_value,
  output logic [1:0]  out_status
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_GET_WAIT,
    S_FIND_RD,
    S_FIND_CHK,
    S_CNT_RD,
    S_CNT_CHK,
    S_ALC_RD,
    S_ALC_CHK,
    S_ALC_MARK,
    S_ALC_LINK,
    S_FREE_RD,
    S_FREE_WR,
    S_RESP
  } state_t;

  state_t state_r;

  // Latched request.
  logic [2:0]       mode_r;
  logic [15:0]      cluster_r;
  logic [15:0]      value_r;
  logic [CNT_W-1:0] want_r;

  // Walk and scan registers.
  logic [ADDR_W-1:0] scan_r;
  logic [ADDR_W-1:0] prev_r;
  logic              have_prev_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  left_r;

  // Pending result.
  logic [15:0] res_found_r;
  logic [15:0] res_entry_r;
  logic [1:0]  res_status_r;

  // Output register.
  logic        out_valid_r;
  logic [15:0] out_found_r;
  logic [15:0] out_entry_r;
  logic [1:0]  out_status_r;

  // Memory port.
  logic [15:0]       mem [FAT_ENTRIES];
  logic [15:0]       mem_rdata_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [15:0]       mem_wdata;

  logic              cl_oor;
  logic              next_oor;
  logic              scan_last;
  logic              rd_free;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [ADDR_W-1:0] cl_addr;

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_found_cluster = out_found_r;
  assign out_entry_value   = out_entry_r;
  assign out_status        = out_status_r;

  // Range and scan flags.
  assign cl_addr   = cluster_r[ADDR_W-1:0];
  assign cl_oor    = ({1'b0, cluster_r} >= FAT_LIMIT);
  assign next_oor  = ({1'b0, mem_rdata_r} >= FAT_LIMIT);
  assign scan_last = (scan_r == ADDR_LAST);
  assign rd_free   = (mem_rdata_r == ENTRY_FREE);
  assign cnt_nxt   = cnt_r + CNT_W'(rd_free);

  // Memory address, write enable and write data for each state.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = scan_r;
    mem_wdata = ENTRY_FREE;
    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (scan_r == ADDR_W'(0)) begin
          mem_wdata = ENTRY_RSV0;
        end else if (scan_r == ADDR_W'(1)) begin
          mem_wdata = ENTRY_END;
        end
      end
      S_DECODE: begin
        mem_addr  = cl_addr;
        mem_wdata = value_r;
        mem_we    = (mode_r == MODE_SET) && !cl_oor && (cluster_r >= 16'd2);
      end
      S_ALC_MARK: begin
        mem_we    = 1'b1;
        mem_wdata = ENTRY_END;
      end
      S_ALC_LINK: begin
        mem_we    = 1'b1;
        mem_addr  = prev_r;
        mem_wdata = 16'(scan_r);
      end
      S_FREE_WR: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Table memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_addr];
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
      have_prev_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_RESP) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          if (scan_last) begin
            state_r <= S_IDLE;
          end
          scan_r <= scan_r + ADDR_W'(1);
        end
        S_IDLE: begin
          if (in_valid) begin
            mode_r    <= in_mode;
            cluster_r <= in_cluster;
            value_r   <= in_value;
            want_r    <= (in_cluster_count == 13'd0) ? CNT_W'(1) : in_cluster_count;
            state_r   <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_found_r  <= 16'd0;
          res_entry_r  <= 16'd0;
          res_status_r <= ST_OK;
          scan_r       <= ADDR_FIRST_DATA;
          cnt_r        <= '0;
          have_prev_r  <= 1'b0;
          case (mode_r)
            MODE_GET: begin
              if (cl_oor) begin
                res_status_r <= ST_RANGE;
                state_r      <= S_RESP;
              end else begin
                state_r <= S_GET_WAIT;
              end
            end
            MODE_SET: begin
              if (cl_oor) begin
                res_status_r <= ST_RANGE;
              end
              state_r <= S_RESP;
            end
            MODE_FIND: begin
              state_r <= S_FIND_RD;
            end
            MODE_ALLOC: begin
              state_r <= S_CNT_RD;
            end
            MODE_FREE: begin
              if (cluster_r < 16'd2 || cluster_r >= ENTRY_END_MIN) begin
                state_r <= S_RESP;
              end else if (cl_oor) begin
                res_status_r <= ST_RANGE;
                state_r      <= S_RESP;
              end else begin
                scan_r  <= cl_addr;
                state_r <= S_FREE_RD;
              end
            end
            default: begin
              state_r <= S_RESP;
            end
          endcase
        end
        S_GET_WAIT: begin
          res_entry_r <= mem_rdata_r;
          state_r     <= S_RESP;
        end
        // Find: lowest zero entry from cluster 2 up.
        S_FIND_RD: begin
          state_r <= S_FIND_CHK;
        end
        S_FIND_CHK: begin
          if (rd_free) begin
            res_found_r <= 16'(scan_r);
            state_r     <= S_RESP;
          end else if (scan_last) begin
            res_status_r <= ST_NO_SPACE;
            state_r      <= S_RESP;
          end else begin
            scan_r  <= scan_r + ADDR_W'(1);
            state_r <= S_FIND_RD;
          end
        end
        // Allocate, first pass: make sure enough entries are free.
        S_CNT_RD: begin
          state_r <= S_CNT_CHK;
        end
        S_CNT_CHK: begin
          cnt_r <= cnt_nxt;
          if (cnt_nxt == want_r) begin
            scan_r  <= ADDR_FIRST_DATA;
            left_r  <= want_r;
            state_r <= S_ALC_RD;
          end else if (scan_last) begin
            res_status_r <= ST_NO_SPACE;
            state_r      <= S_RESP;
          end else begin
            scan_r  <= scan_r + ADDR_W'(1);
            state_r <= S_CNT_RD;
          end
        end
        // Allocate, second pass: mark and link free entries in order.
        S_ALC_RD: begin
          state_r <= S_ALC_CHK;
        end
        S_ALC_CHK: begin
          if (rd_free) begin
            state_r <= S_ALC_MARK;
          end else begin
            scan_r  <= scan_r + ADDR_W'(1);
            state_r <= S_ALC_RD;
          end
        end
        S_ALC_MARK, S_ALC_LINK: begin
          if (state_r == S_ALC_MARK && have_prev_r) begin
            state_r <= S_ALC_LINK;
          end else begin
            if (!have_prev_r) begin
              res_found_r <= 16'(scan_r);
              have_prev_r <= 1'b1;
            end
            prev_r <= scan_r;
            left_r <= left_r - CNT_W'(1);
            if (left_r == CNT_W'(1)) begin
              state_r <= S_RESP;
            end else begin
              scan_r  <= scan_r + ADDR_W'(1);
              state_r <= S_ALC_RD;
            end
          end
        end
        // Free: read the link, clear the entry, follow the link.
        S_FREE_RD: begin
          state_r <= S_FREE_WR;
        end
        S_FREE_WR: begin
          if (mem_rdata_r >= ENTRY_END_MIN || mem_rdata_r < 16'd2) begin
            state_r <= S_RESP;
          end else if (next_oor) begin
            res_status_r <= ST_RANGE;
            state_r      <= S_RESP;
          end else begin
            scan_r  <= mem_rdata_r[ADDR_W-1:0];
            state_r <= S_FREE_RD;
          end
        end
        // Hand the result to the output register once it is free.
        S_RESP: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_found_r  <= res_found_r;
            out_entry_r  <= res_entry_r;
            out_status_r <= res_status_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
